FILE: rtl/cpc_pkg.sv
// Shared types, codes and the result slot table of the control press classifier.
// No dependencies.
`default_nettype none

package cpc_pkg;

  localparam int unsigned NUM_ENC = 2;
  localparam int unsigned NUM_POT = 3;
  localparam int unsigned NUM_BTN = 4;
  localparam int unsigned NUM_CTRL = NUM_ENC + NUM_POT + NUM_BTN;

  // item kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  // configuration register indexes
  localparam logic REG_SHORT_PRESS = 1'b0;
  localparam logic REG_POT_BLOCK   = 1'b1;

  localparam logic [15:0] SHORT_PRESS_RESET = 16'd500;
  localparam logic [15:0] POT_BLOCK_RESET   = 16'd100;

  // event codes
  localparam logic [3:0] EV_ENC_TURN    = 4'd0;
  localparam logic [3:0] EV_POT_TURN    = 4'd1;
  localparam logic [3:0] EV_ENC_PUSH    = 4'd2;
  localparam logic [3:0] EV_ENC_SHORT   = 4'd3;
  localparam logic [3:0] EV_ENC_RELEASE = 4'd4;
  localparam logic [3:0] EV_POT_PUSH    = 4'd5;
  localparam logic [3:0] EV_POT_SHORT   = 4'd6;
  localparam logic [3:0] EV_POT_RELEASE = 4'd7;
  localparam logic [3:0] EV_BTN_PUSH    = 4'd8;
  localparam logic [3:0] EV_BTN_RELEASE = 4'd9;
  localparam logic [3:0] EV_POT_LONG    = 4'd10;
  localparam logic [3:0] EV_ENC_LONG    = 4'd11;

  // result slots of one item, in emission order
  localparam int unsigned NSLOT  = 28;
  localparam int unsigned SLOT_W = $clog2(NSLOT);

  // what one lane found for the item it was shown
  typedef struct packed {
    logic turn;
    logic push;
    logic shrt;
    logic rel;
    logic lng;
  } lane_ev_t;

  typedef struct packed {
    logic [3:0] code;
    logic [1:0] idx;
  } slot_info_t;

  function automatic slot_info_t slot_decode(input logic kind, input logic [SLOT_W-1:0] slot);
    slot_info_t s;
    s.code = EV_ENC_TURN;
    s.idx  = 2'd0;
    if (kind == KIND_POLL) begin
      case (slot)
        5'd0: begin s.code = EV_POT_LONG; s.idx = 2'd0; end
        5'd1: begin s.code = EV_POT_LONG; s.idx = 2'd1; end
        5'd2: begin s.code = EV_POT_LONG; s.idx = 2'd2; end
        5'd3: begin s.code = EV_ENC_LONG; s.idx = 2'd0; end
        5'd4: begin s.code = EV_ENC_LONG; s.idx = 2'd1; end
        default: begin s.code = EV_ENC_LONG; s.idx = 2'd0; end
      endcase
    end else begin
      case (slot)
        5'd0:  begin s.code = EV_ENC_TURN;    s.idx = 2'd0; end
        5'd1:  begin s.code = EV_ENC_TURN;    s.idx = 2'd1; end
        5'd2:  begin s.code = EV_POT_TURN;    s.idx = 2'd0; end
        5'd3:  begin s.code = EV_POT_TURN;    s.idx = 2'd1; end
        5'd4:  begin s.code = EV_POT_TURN;    s.idx = 2'd2; end
        5'd5:  begin s.code = EV_ENC_PUSH;    s.idx = 2'd0; end
        5'd6:  begin s.code = EV_ENC_PUSH;    s.idx = 2'd1; end
        5'd7:  begin s.code = EV_ENC_SHORT;   s.idx = 2'd0; end
        5'd8:  begin s.code = EV_ENC_RELEASE; s.idx = 2'd0; end
        5'd9:  begin s.code = EV_ENC_SHORT;   s.idx = 2'd1; end
        5'd10: begin s.code = EV_ENC_RELEASE; s.idx = 2'd1; end
        5'd11: begin s.code = EV_POT_PUSH;    s.idx = 2'd0; end
        5'd12: begin s.code = EV_POT_PUSH;    s.idx = 2'd1; end
        5'd13: begin s.code = EV_POT_PUSH;    s.idx = 2'd2; end
        5'd14: begin s.code = EV_POT_SHORT;   s.idx = 2'd0; end
        5'd15: begin s.code = EV_POT_RELEASE; s.idx = 2'd0; end
        5'd16: begin s.code = EV_POT_SHORT;   s.idx = 2'd1; end
        5'd17: begin s.code = EV_POT_RELEASE; s.idx = 2'd1; end
        5'd18: begin s.code = EV_POT_SHORT;   s.idx = 2'd2; end
        5'd19: begin s.code = EV_POT_RELEASE; s.idx = 2'd2; end
        5'd20: begin s.code = EV_BTN_PUSH;    s.idx = 2'd0; end
        5'd21: begin s.code = EV_BTN_PUSH;    s.idx = 2'd1; end
        5'd22: begin s.code = EV_BTN_PUSH;    s.idx = 2'd2; end
        5'd23: begin s.code = EV_BTN_PUSH;    s.idx = 2'd3; end
        5'd24: begin s.code = EV_BTN_RELEASE; s.idx = 2'd0; end
        5'd25: begin s.code = EV_BTN_RELEASE; s.idx = 2'd1; end
        5'd26: begin s.code = EV_BTN_RELEASE; s.idx = 2'd2; end
        5'd27: begin s.code = EV_BTN_RELEASE; s.idx = 2'd3; end
        default: begin s.code = EV_BTN_RELEASE; s.idx = 2'd3; end
      endcase
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cpc_enc_lane.sv
// One encoder lane: turn, push, short press, release and long press detection.
// Depends on cpc_pkg.
`default_nettype none

module cpc_enc_lane
  import cpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        kind_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        rise_i,
  input  wire logic        fall_i,
  input  wire logic [7:0]  delta_i,
  input  wire logic [15:0] short_press_ms_i,
  output lane_ev_t         ev_o
);

  logic [31:0] down_time_q, down_time_d;
  logic        long_fired_q, long_fired_d;
  logic        held;
  logic [31:0] elapsed;
  logic        reached;
  logic        is_update;

  assign held      = (down_time_q != 32'd0);
  assign elapsed   = now_ms_i - down_time_q;
  assign reached   = (elapsed >= {16'd0, short_press_ms_i});
  assign is_update = (kind_i == KIND_UPDATE);

  always_comb begin
    ev_o.turn = is_update && (delta_i != 8'd0);
    ev_o.push = is_update && rise_i;
    ev_o.rel  = is_update && fall_i;
    ev_o.shrt = is_update && fall_i && held && !reached;
    ev_o.lng  = !is_update && held && !long_fired_q && reached;
  end

  always_comb begin
    down_time_d  = down_time_q;
    long_fired_d = long_fired_q;
    if (accept_i) begin
      if (!is_update) begin
        if (ev_o.lng) begin
          long_fired_d = 1'b1;
        end
      end else if (rise_i) begin
        down_time_d = now_ms_i;
      end else if (fall_i && held) begin
        if (reached) begin
          long_fired_d = 1'b0;
        end
        down_time_d = 32'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_time_q  <= 32'd0;
      long_fired_q <= 1'b0;
    end else begin
      down_time_q  <= down_time_d;
      long_fired_q <= long_fired_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cpc_pot_lane.sv
// One pot lane: gated turn, push, short press, release, long press and block window.
// Depends on cpc_pkg.
`default_nettype none

module cpc_pot_lane
  import cpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        kind_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        rise_i,
  input  wire logic        fall_i,
  input  wire logic        moved_i,
  input  wire logic [15:0] short_press_ms_i,
  input  wire logic [15:0] pot_block_ms_i,
  output lane_ev_t         ev_o
);

  logic [31:0] down_time_q, down_time_d;
  logic [31:0] block_until_q, block_until_d;
  logic        long_fired_q, long_fired_d;
  logic        held;
  logic [31:0] elapsed;
  logic        reached;
  logic        is_update;

  assign held      = (down_time_q != 32'd0);
  assign elapsed   = now_ms_i - down_time_q;
  assign reached   = (elapsed >= {16'd0, short_press_ms_i});
  assign is_update = (kind_i == KIND_UPDATE);

  always_comb begin
    // plain unsigned compare, a window that wraps blocks nothing
    ev_o.turn = is_update && moved_i && !held && (block_until_q <= now_ms_i);
    ev_o.push = is_update && rise_i;
    ev_o.rel  = is_update && fall_i;
    ev_o.shrt = is_update && fall_i && held && !reached;
    ev_o.lng  = !is_update && held && !long_fired_q && reached;
  end

  always_comb begin
    down_time_d   = down_time_q;
    block_until_d = block_until_q;
    long_fired_d  = long_fired_q;
    if (accept_i) begin
      if (!is_update) begin
        if (ev_o.lng) begin
          long_fired_d = 1'b1;
        end
      end else if (rise_i) begin
        down_time_d = now_ms_i;
      end else if (fall_i && held) begin
        if (reached) begin
          long_fired_d = 1'b0;
        end
        down_time_d   = 32'd0;
        block_until_d = now_ms_i + {16'd0, pot_block_ms_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_time_q   <= 32'd0;
      block_until_q <= 32'd0;
      long_fired_q  <= 1'b0;
    end else begin
      down_time_q   <= down_time_d;
      block_until_q <= block_until_d;
      long_fired_q  <= long_fired_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cpc_merge.sv
// Merging stage: gathers lane findings into an ordered slot mask and serializes one
// result per cycle unless out_ready_i stalls, via an output register. Depends on cpc_pkg.
`default_nettype none

module cpc_merge
  import cpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               kind_i,
  input  wire lane_ev_t           enc_ev_i [NUM_ENC],
  input  wire lane_ev_t           pot_ev_i [NUM_POT],
  input  wire logic [NUM_BTN-1:0] btn_rise_i,
  input  wire logic [NUM_BTN-1:0] btn_fall_i,
  input  wire logic [7:0]         enc1_delta_i,
  input  wire logic [7:0]         enc2_delta_i,
  input  wire logic [15:0]        pot1_value_i,
  input  wire logic [15:0]        pot2_value_i,
  input  wire logic [15:0]        pot3_value_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              event_code_o,
  output logic [1:0]              control_index_o,
  output logic signed [16:0]      event_value_o,
  output logic                    last_o
);

  logic [NSLOT-1:0]   new_mask;
  logic [NSLOT-1:0]   mask_q, mask_d;
  logic [NSLOT-1:0]   mask_after;
  logic               kind_q;
  logic [7:0]         delta_q [NUM_ENC];
  logic [15:0]        potv_q  [NUM_POT];
  logic [SLOT_W-1:0]  sel;
  logic               out_free;
  logic               load_out;
  slot_info_t         info;
  logic signed [16:0] sel_value;

  logic               out_valid_q;
  logic [3:0]         code_q;
  logic [1:0]         idx_q;
  logic signed [16:0] value_q;
  logic               last_q;

  // ordered slot layout of one item
  always_comb begin
    new_mask = '0;
    if (kind_i == KIND_POLL) begin
      new_mask[0] = pot_ev_i[0].lng;
      new_mask[1] = pot_ev_i[1].lng;
      new_mask[2] = pot_ev_i[2].lng;
      new_mask[3] = enc_ev_i[0].lng;
      new_mask[4] = enc_ev_i[1].lng;
    end else begin
      new_mask[0]  = enc_ev_i[0].turn;
      new_mask[1]  = enc_ev_i[1].turn;
      new_mask[2]  = pot_ev_i[0].turn;
      new_mask[3]  = pot_ev_i[1].turn;
      new_mask[4]  = pot_ev_i[2].turn;
      new_mask[5]  = enc_ev_i[0].push;
      new_mask[6]  = enc_ev_i[1].push;
      new_mask[7]  = enc_ev_i[0].shrt;
      new_mask[8]  = enc_ev_i[0].rel;
      new_mask[9]  = enc_ev_i[1].shrt;
      new_mask[10] = enc_ev_i[1].rel;
      new_mask[11] = pot_ev_i[0].push;
      new_mask[12] = pot_ev_i[1].push;
      new_mask[13] = pot_ev_i[2].push;
      new_mask[14] = pot_ev_i[0].shrt;
      new_mask[15] = pot_ev_i[0].rel;
      new_mask[16] = pot_ev_i[1].shrt;
      new_mask[17] = pot_ev_i[1].rel;
      new_mask[18] = pot_ev_i[2].shrt;
      new_mask[19] = pot_ev_i[2].rel;
      new_mask[23:20] = btn_rise_i;
      new_mask[27:24] = btn_fall_i;
    end
  end

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign info = slot_decode(kind_q, sel);

  always_comb begin
    sel_value = '0;
    case (info.code)
      EV_ENC_TURN: begin
        sel_value = {{9{delta_q[info.idx[0]][7]}}, delta_q[info.idx[0]]};
      end
      EV_POT_TURN: begin
        case (info.idx)
          2'd0:    sel_value = {1'b0, potv_q[0]};
          2'd1:    sel_value = {1'b0, potv_q[1]};
          default: sel_value = {1'b0, potv_q[2]};
        endcase
      end
      default: sel_value = '0;
    endcase
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = out_free && (mask_q != '0);
  assign mask_after = mask_q & ~(NSLOT'(1) << sel);
  assign in_ready_o = (mask_q == '0) || (load_out && (mask_after == '0));

  always_comb begin
    mask_d = mask_q;
    if (load_out) begin
      mask_d = mask_after;
    end
    if (accept_i) begin
      mask_d = new_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      kind_q     <= kind_i;
      delta_q[0] <= enc1_delta_i;
      delta_q[1] <= enc2_delta_i;
      potv_q[0]  <= pot1_value_i;
      potv_q[1]  <= pot2_value_i;
      potv_q[2]  <= pot3_value_i;
    end
    if (load_out) begin
      code_q  <= info.code;
      idx_q   <= info.idx;
      value_q <= sel_value;
      last_q  <= (mask_after == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_code_o    = code_q;
  assign control_index_o = idx_q;
  assign event_value_o   = value_q;
  assign last_o          = last_q;

  // a poll item only ever fills the long press slots
  a_poll_layout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0 && kind_q == KIND_POLL) |-> (mask_q[NSLOT-1:5] == '0))
    else $error("poll item holds update slots");

  // a result that is not the last leaves events of its item pending
  a_pending_after_nonlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (mask_q != '0))
    else $error("non-last result with nothing pending");

  // each serializer step retires exactly one slot
  a_one_per_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !accept_i) |=> ($countones(mask_q) == $countones($past(mask_q)) - 1))
    else $error("serializer retired other than one slot");

endmodule

`default_nettype wire

FILE: rtl/control_press_classifier.sv
// Control press classifier top level: config registers, encoder and pot lanes, merge.
// Depends on cpc_pkg, cpc_enc_lane, cpc_pot_lane and cpc_merge.
//
// Each encoder and pot has a lane of its own that keeps its push time, long
// press flag and (for pots) turn blocking window, and all lanes judge an item
// in the cycle it is accepted; button edges need no state. The merging stage
// sorts what the lanes found into the fixed event order and hands out one
// result per cycle, while out_ready_i does not stall it, through an output
// register. An update item causes at most 16 results and a poll item 5, and
// the next item is taken in the cycle its predecessor's last result is
// loaded; an item that causes no result leaves the stage ready again. Times
// differ modulo 2^32; a push at time zero reads as not held.
`default_nettype none

module control_press_classifier
  import cpc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic [8:0]         pressed_now_i,
  input  wire logic [8:0]         pressed_before_i,
  input  wire logic [2:0]         pot_moved_i,
  input  wire logic signed [7:0]  enc1_delta_i,
  input  wire logic signed [7:0]  enc2_delta_i,
  input  wire logic [15:0]        pot1_value_i,
  input  wire logic [15:0]        pot2_value_i,
  input  wire logic [15:0]        pot3_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              event_code_o,
  output logic [1:0]              control_index_o,
  output logic signed [16:0]      event_value_o,
  output logic                    last_o
);

  logic [15:0]         short_press_q;
  logic [15:0]         pot_block_q;
  logic                accept;
  logic [NUM_CTRL-1:0] rise;
  logic [NUM_CTRL-1:0] fall;
  logic [7:0]          enc_delta [NUM_ENC];
  lane_ev_t            enc_ev [NUM_ENC];
  lane_ev_t            pot_ev [NUM_POT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_press_q <= SHORT_PRESS_RESET;
      pot_block_q   <= POT_BLOCK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHORT_PRESS: short_press_q <= cfg_wdata_i;
        REG_POT_BLOCK:   pot_block_q   <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  assign accept       = in_valid_i && in_ready_o;
  assign rise         = pressed_now_i & ~pressed_before_i;
  assign fall         = pressed_before_i & ~pressed_now_i;
  assign enc_delta[0] = enc1_delta_i;
  assign enc_delta[1] = enc2_delta_i;

  for (genvar g = 0; g < NUM_ENC; g++) begin : g_enc
    cpc_enc_lane u_enc (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .accept_i         (accept),
      .kind_i           (kind_i),
      .now_ms_i         (now_ms_i),
      .rise_i           (rise[g]),
      .fall_i           (fall[g]),
      .delta_i          (enc_delta[g]),
      .short_press_ms_i (short_press_q),
      .ev_o             (enc_ev[g])
    );
  end

  for (genvar g = 0; g < NUM_POT; g++) begin : g_pot
    cpc_pot_lane u_pot (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .accept_i         (accept),
      .kind_i           (kind_i),
      .now_ms_i         (now_ms_i),
      .rise_i           (rise[NUM_ENC + g]),
      .fall_i           (fall[NUM_ENC + g]),
      .moved_i          (pot_moved_i[g]),
      .short_press_ms_i (short_press_q),
      .pot_block_ms_i   (pot_block_q),
      .ev_o             (pot_ev[g])
    );
  end

  cpc_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .kind_i          (kind_i),
    .enc_ev_i        (enc_ev),
    .pot_ev_i        (pot_ev),
    .btn_rise_i      (rise[NUM_CTRL-1:NUM_ENC+NUM_POT]),
    .btn_fall_i      (fall[NUM_CTRL-1:NUM_ENC+NUM_POT]),
    .enc1_delta_i    (enc1_delta_i),
    .enc2_delta_i    (enc2_delta_i),
    .pot1_value_i    (pot1_value_i),
    .pot2_value_i    (pot2_value_i),
    .pot3_value_i    (pot3_value_i),
    .in_ready_o      (in_ready_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_code_o    (event_code_o),
    .control_index_o (control_index_o),
    .event_value_o   (event_value_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
